/* design/nnis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types, constants and helpers of the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

  localparam int MAX_DIM_DEF = 256;
  localparam int COORD_W     = 8;
  localparam int DIM_W       = 9;
  localparam int PIX_W       = 32;
  localparam int BYTES_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int PROD_W      = COORD_W + DIM_W;
  localparam int QUOT_W      = DIM_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BYTES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BYTES  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_Y_REVERSE  = 3'd6;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FETCH,
    OP_RANGE,
    OP_DROP
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_DIV,
    S_READ,
    S_OUT
  } bstate_t;

  // effective configuration
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [PIX_W-1:0] mask;
    logic             y_rev;
  } cfg_t;

  // queue word
  typedef struct packed {
    op_t                kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pixel;
  } entry_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxd);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > maxd) r = DIM_W'(maxd);
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] clamp_bytes(input logic [BYTES_W-1:0] v);
    logic [BYTES_W-1:0] r;
    r = v;
    if (v == '0) r = BYTES_W'(1);
    else if (v > BYTES_W'(4)) r = BYTES_W'(4);
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
    logic [PIX_W-1:0] m;
    case (n)
      3'd1: m = 32'h0000_00FF;
      3'd2: m = 32'h0000_FFFF;
      3'd3: m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

/* design/nnis_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_front
// Accepts command words and classifies them into store loads, fetches,
// out-of-range fetches and dropped loads before they enter the queue.
// ----------------------------------------------------------------------------
module nnis_front #(
  parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF
) (
  input  logic                         start,
  input  logic                         busy,
  input  logic                         command,
  input  logic [nnis_pkg::COORD_W-1:0] coord_x,
  input  logic [nnis_pkg::COORD_W-1:0] coord_y,
  input  logic [nnis_pkg::PIX_W-1:0]   pixel_in,
  input  nnis_pkg::cfg_t               cfg,
  output logic                         push,
  output nnis_pkg::entry_t             word
);
  import nnis_pkg::*;

  logic in_store;
  logic in_dst;
  op_t  kind;

  assign in_store = (int'(coord_x) < MAX_DIM) && (int'(coord_y) < MAX_DIM);
  assign in_dst   = ({1'b0, coord_x} < cfg.dw) && ({1'b0, coord_y} < cfg.dh);

  always_comb begin
    if (command == CMD_LOAD) begin
      kind = in_store ? OP_LOAD : OP_DROP;
    end else begin
      kind = in_dst ? OP_FETCH : OP_RANGE;
    end
  end

  assign push       = start && !busy && (kind != OP_DROP);
  assign word.kind  = kind;
  assign word.x     = coord_x;
  assign word.y     = coord_y;
  assign word.pixel = pixel_in;

endmodule

/* design/nnis_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_queue
// Short in-order queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module nnis_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nnis_pkg::entry_t wdata,
  input  logic             pop,
  output nnis_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import nnis_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + CNT_W'(1);
    else if (pop && !push) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* design/nnis_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_div
// Radix-2 restoring divider, one quotient bit per cycle. The quotient is
// known to fit QUOT_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module nnis_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nnis_pkg::PROD_W-1:0] dividend,
  input  logic [nnis_pkg::DIM_W-1:0]  divisor,
  output logic                        finish,
  output logic [nnis_pkg::QUOT_W-1:0] quotient
);
  import nnis_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [DIM_W-1:0]  rem;
  logic [QUOT_W-1:0] qsh;
  logic [DIM_W-1:0]  dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIM_W:0]    trial;
  logic              ge;

  assign trial    = {rem, qsh[QUOT_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      cnt    <= '0;
    end else begin
      finish <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(QUOT_W - 1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DIM_W'(dividend[PROD_W-1:QUOT_W]);
      qsh <= dividend[QUOT_W-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? DIM_W'(trial - {1'b0, dsr}) : trial[DIM_W-1:0];
      qsh <= {qsh[QUOT_W-2:0], ge};
    end
  end

  a_rem_below: assert property (@(posedge clk) disable iff (rst) busy |-> (rem < dsr))
    else $error("partial remainder not below divisor");

endmodule

/* design/nnis_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_back
// Back end: drains the queue, writes loads into the frame store, maps
// fetches to source coordinates through two dividers and reads the store.
// ----------------------------------------------------------------------------
module nnis_back #(
  parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nnis_pkg::cfg_t             cfg,
  input  nnis_pkg::entry_t           head,
  input  logic                       empty,
  output logic                       pop,
  output logic                       done,
  output logic [nnis_pkg::PIX_W-1:0] pixel_out,
  output logic                       range_error
);
  import nnis_pkg::*;

  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  bstate_t state;
  bstate_t state_next;

  logic [PIX_W-1:0]   mem [DEPTH];
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic               err;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [PIX_W-1:0]   rd_data;
  logic               mem_we;
  logic               div_start;
  logic               fin_x;
  logic               fin_y;
  logic [QUOT_W-1:0]  qx;
  logic [QUOT_W-1:0]  qy;
  logic [DIM_W-1:0]   sy;

  nnis_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (cfg.dw),
    .finish   (fin_x),
    .quotient (qx)
  );

  nnis_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (cfg.dh),
    .finish   (fin_y),
    .quotient (qy)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (head.kind == OP_FETCH) state_next = S_MUL;
          else if (head.kind == OP_RANGE) state_next = S_OUT;
        end
      end
      S_MUL:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (fin_x && fin_y) state_next = S_READ;
      S_READ:  state_next = S_OUT;
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    case (state)
      S_IDLE:  pop = !empty;
      S_START: div_start = 1'b1;
      default: begin
        pop       = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  assign mem_we  = pop && (head.kind == OP_LOAD);
  assign wr_addr = {CW'(head.y), CW'(head.x)};
  assign sy      = cfg.y_rev ? (cfg.sh - DIM_W'(1) - qy) : qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx  <= head.x;
      cy  <= head.y;
      err <= (head.kind == OP_RANGE);
    end
    if (state == S_MUL) begin
      prod_x <= PROD_W'(cx) * PROD_W'(cfg.sw);
      prod_y <= PROD_W'(cy) * PROD_W'(cfg.sh);
    end
    if (state == S_DIV) begin
      rd_addr <= {CW'(sy), CW'(qx)};
    end
    if (state == S_OUT) begin
      pixel_out   <= err ? '0 : (rd_data & cfg.mask);
      range_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= head.pixel;
    if (state == S_READ) rd_data <= mem[rd_addr];
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_OUT))
    else $error("result strobe without output state");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (pixel_out == '0))
    else $error("range error with nonzero pixel");

endmodule

/* design/nearest_neighbour_image_scaler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_image_scaler
// Nearest-neighbor image scaler around a source frame store.
//
//   channel  | handshake           | word
//   ---------+---------------------+--------------------------------------
//   command  | start / busy        | command, coord_x, coord_y, pixel_in
//   result   | done (strobe)       | pixel_out, range_error
//   config   | cfg_we              | cfg_index, cfg_data
//
// A load is written to the store as it is popped; a fetch holds the back end
// through multiply, divider start, radix-2 division, store read and output.
// A word is taken whenever the two-entry queue has room, so busy rises only
// while the back end works off a full queue. Results appear in command order.
// Synchronous reset empties the queue and idles the back end; the frame store
// is not cleared. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module nearest_neighbour_image_scaler #(
  parameter int MAX_DIM = nnis_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [nnis_pkg::COORD_W-1:0]    coord_x,
  input  logic [nnis_pkg::COORD_W-1:0]    coord_y,
  input  logic [nnis_pkg::PIX_W-1:0]      pixel_in,
  output logic                            done,
  output logic [nnis_pkg::PIX_W-1:0]      pixel_out,
  output logic                            range_error,
  input  logic                            cfg_we,
  input  logic [nnis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nnis_pkg::*;

  logic [DIM_W-1:0]   src_width;
  logic [DIM_W-1:0]   src_height;
  logic [DIM_W-1:0]   dst_width;
  logic [DIM_W-1:0]   dst_height;
  logic [BYTES_W-1:0] src_bytes;
  logic [BYTES_W-1:0] dst_bytes;
  logic               y_reverse;

  cfg_t               cfg;
  logic [BYTES_W-1:0] sb;
  logic [BYTES_W-1:0] db;
  logic               push;
  entry_t             wword;
  entry_t             head;
  logic               empty;
  logic               full;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(256);
      src_height <= DIM_W'(256);
      dst_width  <= DIM_W'(256);
      dst_height <= DIM_W'(256);
      src_bytes  <= BYTES_W'(4);
      dst_bytes  <= BYTES_W'(4);
      y_reverse  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        REG_SRC_BYTES:  src_bytes  <= cfg_data[BYTES_W-1:0];
        REG_DST_BYTES:  dst_bytes  <= cfg_data[BYTES_W-1:0];
        REG_Y_REVERSE:  y_reverse  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign sb        = clamp_bytes(src_bytes);
  assign db        = clamp_bytes(dst_bytes);
  assign cfg.sw    = clamp_dim(src_width, MAX_DIM);
  assign cfg.sh    = clamp_dim(src_height, MAX_DIM);
  assign cfg.dw    = clamp_dim(dst_width, MAX_DIM);
  assign cfg.dh    = clamp_dim(dst_height, MAX_DIM);
  assign cfg.mask  = byte_mask((sb < db) ? sb : db);
  assign cfg.y_rev = y_reverse;

  assign busy = full;

  nnis_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .command  (command),
    .coord_x  (coord_x),
    .coord_y  (coord_y),
    .pixel_in (pixel_in),
    .cfg      (cfg),
    .push     (push),
    .word     (wword)
  );

  nnis_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wword),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  nnis_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .done        (done),
    .pixel_out   (pixel_out),
    .range_error (range_error)
  );

endmodule
